@@ sv/periodic_pair_distance_macros.svh @@
// assertion macros for the periodic pair distance block
`ifndef PERIODIC_PAIR_DISTANCE_MACROS_SVH
`define PERIODIC_PAIR_DISTANCE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ppd_pkg.sv @@
// shared types and constants of the periodic pair distance block
`timescale 1ns / 1ps
package ppd_pkg;

  localparam int ATOM_SLOTS_DEF = 4096;
  localparam int COORD_BITS_DEF = 20;
  localparam int LANE_BITS      = 20;
  localparam int REG_BITS       = 60;
  localparam int SLOT_BITS      = 12;
  localparam int DIST_BITS      = 21;
  localparam int FRAC_SHIFT     = 30;
  localparam int INV_BITS       = 20;
  localparam int FRAC_BITS      = 31;

  // operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  // register indexes
  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_BOX_A = 3'd1,
    REG_BOX_B = 3'd2,
    REG_BOX_C = 3'd3,
    REG_INV_A = 3'd4,
    REG_INV_B = 3'd5,
    REG_INV_C = 3'd6
  } reg_index_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_FRAC = 6'b000100,
    S_CART = 6'b001000,
    S_SQ   = 6'b010000,
    S_ROOT = 6'b100000
  } state_t;

  // status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } root_status_t;

endpackage

@@ sv/periodic_pair_distance.sv @@
// top level: atom memory, minimum image sequencer and distance output
//
// Usage: a transaction is taken when start is high and busy is low.
// operation = load writes coord_x/y/z into slot atom_slot in that cycle and
// gives no result; busy stays low, so loads may come every cycle.
// operation = measure reads first_atom and second_atom from the two read
// ports of the atom memory and raises busy until its result appears.
// The result is on distance for one cycle with strobe high; it cannot be
// held off. The time a measure takes is set by the single shared
// multiplier, which does one multiply-accumulate at a time (21 of them in
// periodic mode), and by the square root unit, which resolves one result
// bit per cycle. Configuration writes (cfg_write, cfg_index, cfg_data)
// take effect at once; the user must make them while busy is low, as the
// block itself does not enforce it. Reset clears the registers and the
// sequencer; the atom memory holds no defined contents until loaded.
`timescale 1ns / 1ps
module periodic_pair_distance
  import ppd_pkg::*;
#(
  parameter int ATOM_SLOTS = ATOM_SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [SLOT_BITS-1:0]         atom_slot,
  input  logic signed [LANE_BITS-1:0]  coord_x,
  input  logic signed [LANE_BITS-1:0]  coord_y,
  input  logic signed [LANE_BITS-1:0]  coord_z,
  input  logic [SLOT_BITS-1:0]         first_atom,
  input  logic [SLOT_BITS-1:0]         second_atom,
  input  logic                         cfg_write,
  input  logic [2:0]                   cfg_index,
  input  logic [REG_BITS-1:0]          cfg_data,
  output logic                         strobe,
  output logic [DIST_BITS-1:0]         distance
);

  `include "periodic_pair_distance_macros.svh"

  localparam int ADDR_W = $clog2(ATOM_SLOTS);
  localparam int ENTRY_W = 3 * COORD_BITS;
  localparam int D_W    = COORD_BITS + 1;
  localparam int MA_W   = FRAC_BITS;
  localparam int MB_W   = D_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = COORD_BITS + 32;
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam logic [FRAC_SHIFT-1:0] HALF = FRAC_SHIFT'(1) << (FRAC_SHIFT - 1);
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // configuration registers
  logic                periodic_mode;
  logic [REG_BITS-1:0] box_row [3];
  logic [REG_BITS-1:0] inv_row [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_mode <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        box_row[i] <= '0;
        inv_row[i] <= '0;
      end
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_MODE:  periodic_mode <= cfg_data[0];
        REG_BOX_A: box_row[0] <= cfg_data;
        REG_BOX_B: box_row[1] <= cfg_data;
        REG_BOX_C: box_row[2] <= cfg_data;
        REG_INV_A: inv_row[0] <= cfg_data;
        REG_INV_B: inv_row[1] <= cfg_data;
        REG_INV_C: inv_row[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // register lanes
  logic signed [COORD_BITS-1:0] box_lane [3][3];
  logic signed [INV_BITS-1:0]   inv_lane [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        box_lane[i][k] = box_row[i][LANE_BITS*k +: COORD_BITS];
        inv_lane[i][k] = inv_row[i][LANE_BITS*k +: INV_BITS];
      end
    end
  end

  // atom memory, one write port and two read ports
  logic [ENTRY_W-1:0] atom_mem [ATOM_SLOTS];
  logic [ENTRY_W-1:0] rd_a;
  logic [ENTRY_W-1:0] rd_b;
  logic               accept;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  addr_a;
  logic [ADDR_W-1:0]  addr_b;

  assign accept  = start && !busy;
  assign wr_addr = ADDR_W'(32'(atom_slot) % ATOM_SLOTS);
  assign addr_a  = ADDR_W'(32'(first_atom) % ATOM_SLOTS);
  assign addr_b  = ADDR_W'(32'(second_atom) % ATOM_SLOTS);

  always_ff @(posedge clk) begin
    if (accept && operation == OP_LOAD) begin
      atom_mem[wr_addr] <= {coord_z[COORD_BITS-1:0], coord_y[COORD_BITS-1:0],
                            coord_x[COORD_BITS-1:0]};
    end
    rd_a <= atom_mem[addr_a];
    rd_b <= atom_mem[addr_b];
  end

  // sequencer state
  state_t                   state;
  logic [1:0]               ocnt;
  logic [1:0]               icnt;
  logic                     half;
  logic signed [D_W-1:0]    d [3];
  logic signed [D_W-1:0]    r [3];
  logic signed [FRAC_BITS-1:0] f [3];
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  sum_next;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     root_go;
  logic [SQ_W-1:0]          root_value;
  root_status_t             root_status;
  logic [ROOT_W-1:0]        root;

  assign busy = (state != S_IDLE);

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_FRAC: begin
        mul_a = MA_W'(inv_lane[ocnt][icnt]);
        mul_b = d[icnt];
      end
      S_CART: begin
        mul_a = f[icnt];
        mul_b = MB_W'(box_lane[icnt][ocnt]);
      end
      default: begin
        mul_a = MA_W'(r[icnt]);
        mul_b = r[icnt];
      end
    endcase
  end

  assign sum_next = acc + ACC_W'(prod);

  // nearest integer reduction: the fraction rounds ties to even, the Cartesian result rounds ties up
  logic [FRAC_SHIFT-1:0]       rem_lo;
  logic                        round_up;
  logic signed [FRAC_BITS-1:0] frac_val;
  logic signed [ACC_W-1:0]     cart_round;

  assign rem_lo   = sum_next[FRAC_SHIFT-1:0];
  assign round_up = (rem_lo > HALF) || (rem_lo == HALF && sum_next[FRAC_SHIFT]);
  assign frac_val = FRAC_BITS'($signed({1'b0, rem_lo}) -
                    (round_up ? $signed({1'b0, HALF, 1'b0}) : 32'sd0));
  assign cart_round = (sum_next + ACC_W'(HALF)) >>> FRAC_SHIFT;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      root_go <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      root_go <= 1'b0;
      strobe  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && operation == OP_MEASURE) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= periodic_mode ? S_FRAC : S_SQ;
        end
        S_FRAC, S_CART, S_SQ: begin
          if (half && icnt == 2'd2) begin
            if (state == S_SQ) begin
              state   <= S_ROOT;
              root_go <= 1'b1;
            end else if (ocnt == 2'd2) begin
              state <= (state == S_FRAC) ? S_CART : S_SQ;
            end
          end
        end
        S_ROOT: begin
          if (root_status.done) begin
            state  <= S_IDLE;
            strobe <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_READ: begin
        for (int k = 0; k < 3; k++) begin
          d[k] <= D_W'($signed(rd_b[COORD_BITS*k +: COORD_BITS])) -
                  D_W'($signed(rd_a[COORD_BITS*k +: COORD_BITS]));
          r[k] <= D_W'($signed(rd_b[COORD_BITS*k +: COORD_BITS])) -
                  D_W'($signed(rd_a[COORD_BITS*k +: COORD_BITS]));
        end
        ocnt <= '0;
        icnt <= '0;
        half <= 1'b0;
        acc  <= '0;
      end
      S_FRAC, S_CART, S_SQ: begin
        if (!half) begin
          prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
          half <= 1'b1;
        end else begin
          half <= 1'b0;
          if (icnt == 2'd2) begin
            icnt <= '0;
            // the sum of squares stays in acc for the root unit
            acc  <= (state == S_SQ) ? sum_next : '0;
            ocnt <= (ocnt == 2'd2) ? 2'd0 : ocnt + 2'd1;
            if (state == S_FRAC) begin
              f[ocnt] <= frac_val;
            end else if (state == S_CART) begin
              r[ocnt] <= D_W'(cart_round);
            end
          end else begin
            icnt <= icnt + 2'd1;
            acc  <= sum_next;
          end
        end
      end
      default: ;
    endcase
  end

  assign root_value = SQ_W'(acc);

  ppd_root #(
    .ROOT_W (ROOT_W)
  ) u_root (
    .clk    (clk),
    .rst    (rst),
    .go     (root_go),
    .value  (root_value),
    .status (root_status),
    .root   (root)
  );

  // saturated result
  always_ff @(posedge clk) begin
    if (root_status.done) begin
      distance <= (32'(root) > 32'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(root);
    end
  end

  // checks
  `PPD_ASSERT_NOW(a_strobe_idle, strobe, !busy, "result while sequencer busy")
  `PPD_ASSERT_NEXT(a_measure_busy, accept && operation == OP_MEASURE, busy,
    "measure did not start")
  `PPD_ASSERT_NEXT(a_load_quiet, accept && operation == OP_LOAD, !busy && !strobe,
    "load caused activity")
  `PPD_ASSERT_NOW(a_root_only_in_root, root_status.done, state == S_ROOT,
    "root finished outside its phase")

endmodule

@@ sv/ppd_root.sv @@
// iterative floor square root, two radicand bits per cycle
`timescale 1ns / 1ps
module ppd_root
  import ppd_pkg::*;
#(
  parameter int ROOT_W = COORD_BITS_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [2*ROOT_W-1:0]   value,
  output root_status_t          status,
  output logic [ROOT_W-1:0]     root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W+1:0]   rem;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;

  // one digit step
  assign rem_sh = {rem[ROOT_W-1:0], rad[2*ROOT_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      rad  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*ROOT_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule
